### hw/rtl/csv_header_field_splitter_defines.svh
// assertion macros for the csv header field splitter
`ifndef CSV_HEADER_FIELD_SPLITTER_DEFINES_SVH
`define CSV_HEADER_FIELD_SPLITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CSVHFS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csvhfs check failed: same-cycle implication");

// next-cycle implication
`define CSVHFS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csvhfs check failed: next-cycle implication");

`else

`define CSVHFS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CSVHFS_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/csvhfs_pkg.sv
`default_nettype none

package csvhfs_pkg;

   // character codes
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_QUOTE = 8'd34;
   localparam logic [7:0] CH_COMMA = 8'd44;

   // result status codes
   localparam logic [1:0] ST_BYTE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_LONG  = 2'd2;

   // what an accepted beat asks of the sequencer
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SINGLE = 2'd1,
      ACT_BURST  = 2'd2
   } act_type;

   // datapath to controller
   typedef struct packed {
      act_type act;
      logic    out_free;
      logic    burst_last;
   } dp_status_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_single;
      logic fetch;
      logic send;
   } ctl_cmd_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) || (c == CH_SPACE);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/csvhfs_req_if.sv
`default_nettype none

interface csvhfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

`default_nettype wire

### hw/rtl/csvhfs_rsp_if.sv
`default_nettype none

interface csvhfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] field_byte;
   logic [7:0] column_index;
   logic       last_of_field;
   logic [1:0] status;

   modport source (output valid, field_byte, column_index, last_of_field, status,
                   input ready);
   modport sink (input valid, field_byte, column_index, last_of_field, status,
                 output ready);
endinterface

`default_nettype wire

### hw/rtl/csvhfs_ram.sv
`default_nettype none

module csvhfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/csvhfs_datapath.sv
`default_nettype none

module csvhfs_datapath
   import csvhfs_pkg::*;
#(
   parameter int MAX_FIELD_BYTES = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [7:0]    req_text_byte,
   input  wire logic          req_end_of_text,
   input  wire ctl_cmd_type   cmd,
   output dp_status_type      status,
   input  wire logic          rsp_ready,
   output logic               rsp_valid,
   output logic [7:0]         rsp_field_byte,
   output logic [7:0]         rsp_column_index,
   output logic               rsp_last_of_field,
   output logic [1:0]         rsp_status
);

   localparam int ADDR_W = $clog2(MAX_FIELD_BYTES);
   localparam int LEN_W  = $clog2(MAX_FIELD_BYTES + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD_BYTES);

   // header scan state
   logic              quote_ff, quote_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        col_ff, col_in;
   logic              stop_ff, stop_in;

   // running trim bounds of the open field
   logic              any_ff, any_in;
   logic [ADDR_W-1:0] lo_ff, lo_in;
   logic [ADDR_W-1:0] hi_ff, hi_in;
   logic              loq_ff, loq_in;
   logic              hiq_ff, hiq_in;

   // emission of a closed field
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [7:0]        ecol_ff, ecol_in;
   logic [1:0]        sst_ff, sst_in;

   // output register
   logic              ovalid_ff, ovalid_in;
   logic [7:0]        obyte_ff, obyte_in;
   logic [7:0]        ocol_ff, ocol_in;
   logic              olast_ff, olast_in;
   logic [1:0]        ost_ff, ost_in;

   logic              do_store;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        ram_rd;
   act_type           act;
   act_type           close_act;
   logic [1:0]        close_st;
   logic [1:0]        single_st;
   logic              strip;
   logic              narrow;
   logic [ADDR_W-1:0] start_pos;
   logic [ADDR_W-1:0] stop_pos;
   logic [7:0]        col_inc;
   logic              is_sep;

   assign wr_addr = len_ff[ADDR_W-1:0];
   assign col_inc = (col_ff != 8'hFF) ? (col_ff + 8'd1) : col_ff;
   assign is_sep  = (req_text_byte == CH_COMMA) || (req_text_byte == CH_LF);

   // outcome of closing the open field, one pair of outer quotes stripped
   assign strip     = (hi_ff > lo_ff) && loq_ff && hiq_ff;
   assign narrow    = (hi_ff == (lo_ff + ADDR_W'(1)));
   assign start_pos = strip ? (lo_ff + ADDR_W'(1)) : lo_ff;
   assign stop_pos  = strip ? (hi_ff - ADDR_W'(1)) : hi_ff;

   always_comb begin
      close_act = ACT_BURST;
      close_st  = ST_BYTE;
      if (!any_ff) begin
         close_act = ACT_SINGLE;
         close_st  = ST_EMPTY;
      end else if (strip && narrow) begin
         close_act = ACT_SINGLE;
      end
   end

   // beat decode and next scan state
   always_comb begin
      act       = ACT_NONE;
      single_st = close_st;
      do_store  = 1'b0;
      quote_in  = quote_ff;
      len_in    = len_ff;
      col_in    = col_ff;
      stop_in   = stop_ff;
      any_in    = any_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      loq_in    = loq_ff;
      hiq_in    = hiq_ff;
      if (req_end_of_text) begin
         if (!stop_ff && !quote_ff) begin
            act = close_act;
         end
         quote_in = 1'b0;
         len_in   = '0;
         col_in   = '0;
         stop_in  = 1'b0;
         any_in   = 1'b0;
      end else if (stop_ff) begin
         act = ACT_NONE;
      end else if (!quote_ff && is_sep) begin
         act    = close_act;
         len_in = '0;
         any_in = 1'b0;
         if (!any_ff || (req_text_byte == CH_LF)) begin
            stop_in = 1'b1;
         end
         if (any_ff) begin
            col_in = col_inc;
         end
      end else if (len_ff >= MAX_LEN) begin
         act       = ACT_SINGLE;
         single_st = ST_LONG;
         stop_in   = 1'b1;
         len_in    = '0;
         any_in    = 1'b0;
      end else begin
         do_store = 1'b1;
         len_in   = len_ff + LEN_W'(1);
         if (req_text_byte == CH_QUOTE) begin
            quote_in = !quote_ff;
         end
         if (!is_blank(req_text_byte)) begin
            any_in = 1'b1;
            hi_in  = wr_addr;
            hiq_in = (req_text_byte == CH_QUOTE);
            if (!any_ff) begin
               lo_in  = wr_addr;
               loq_in = (req_text_byte == CH_QUOTE);
            end
         end
      end
   end

   // emission pointer and latched close results
   always_comb begin
      ptr_in  = ptr_ff;
      end_in  = end_ff;
      ecol_in = ecol_ff;
      sst_in  = sst_ff;
      if (cmd.accept) begin
         ptr_in  = start_pos;
         end_in  = stop_pos;
         ecol_in = col_ff;
         sst_in  = single_st;
      end else if (cmd.send) begin
         ptr_in = ptr_ff + ADDR_W'(1);
      end
   end

   // output register loads
   always_comb begin
      ovalid_in = ovalid_ff;
      obyte_in  = obyte_ff;
      ocol_in   = ocol_ff;
      olast_in  = olast_ff;
      ost_in    = ost_ff;
      if (cmd.load_single) begin
         ovalid_in = 1'b1;
         obyte_in  = 8'd0;
         ocol_in   = ecol_ff;
         olast_in  = 1'b1;
         ost_in    = sst_ff;
      end else if (cmd.send) begin
         ovalid_in = 1'b1;
         obyte_in  = ram_rd;
         ocol_in   = ecol_ff;
         olast_in  = (ptr_ff == end_ff);
         ost_in    = ST_BYTE;
      end else if (rsp_ready) begin
         ovalid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff  <= 1'b0;
         len_ff    <= '0;
         col_ff    <= '0;
         stop_ff   <= 1'b0;
         any_ff    <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            quote_ff <= quote_in;
            len_ff   <= len_in;
            col_ff   <= col_in;
            stop_ff  <= stop_in;
            any_ff   <= any_in;
         end
         ovalid_ff <= ovalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         loq_ff <= loq_in;
         hiq_ff <= hiq_in;
      end
      ptr_ff   <= ptr_in;
      end_ff   <= end_in;
      ecol_ff  <= ecol_in;
      sst_ff   <= sst_in;
      obyte_ff <= obyte_in;
      ocol_ff  <= ocol_in;
      olast_ff <= olast_in;
      ost_ff   <= ost_in;
   end

   // field store
   csvhfs_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FIELD_BYTES)
   ) u_field_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && do_store),
      .wr_addr (wr_addr),
      .wr_data (req_text_byte),
      .rd_en   (cmd.fetch),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd)
   );

   assign status.act        = act;
   assign status.out_free   = !ovalid_ff || rsp_ready;
   assign status.burst_last = (ptr_ff == end_ff);

   assign rsp_valid         = ovalid_ff;
   assign rsp_field_byte    = obyte_ff;
   assign rsp_column_index  = ocol_ff;
   assign rsp_last_of_field = olast_ff;
   assign rsp_status        = ost_ff;

endmodule

`default_nettype wire

### hw/rtl/csvhfs_ctrl.sv
`default_nettype none

module csvhfs_ctrl
   import csvhfs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SINGLE = 4'b0010,
      S_FETCH  = 4'b0100,
      S_SEND   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // sequencer: take a beat, then walk out whatever it closed
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               case (status.act)
                  ACT_SINGLE: state_in = S_SINGLE;
                  ACT_BURST:  state_in = S_FETCH;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_SINGLE: begin
            if (status.out_free) begin
               cmd.load_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_SEND;
         end
         S_SEND: begin
            if (status.out_free) begin
               cmd.send = 1'b1;
               state_in = status.burst_last ? S_IDLE : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/csv_header_field_splitter.sv
// CSV header field splitter. Header text comes in one byte per req beat; an
// end_of_text beat closes any open unquoted field and rearms the block for the
// next header. Each closed field is trimmed of tab, CR, LF and space, loses
// one pair of outer quotes, and goes out one rsp beat per byte with its column
// index and a last marker; empty and overlong fields give one error beat and
// stop the header until end_of_text. A beat that gives a single result (error
// or quoted empty name) has it loaded into the output register once that is
// free; for a beat that closes a field, each byte is read from the field RAM
// (registered read) in the fetch state and loaded into the output register in
// the send state, which waits while the output is held. No input is taken
// while a closed field is being sent. The field store needs no clearing after
// reset.
`default_nettype none

`include "csv_header_field_splitter_defines.svh"

module csv_header_field_splitter
   import csvhfs_pkg::*;
#(
   parameter int MAX_FIELD_BYTES = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   csvhfs_req_if.sink   req_chan,
   csvhfs_rsp_if.source rsp_chan
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequencer
   csvhfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // scan state, field store and output register
   csvhfs_datapath #(
      .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_text_byte     (req_chan.text_byte),
      .req_end_of_text   (req_chan.end_of_text),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_field_byte    (rsp_chan.field_byte),
      .rsp_column_index  (rsp_chan.column_index),
      .rsp_last_of_field (rsp_chan.last_of_field),
      .rsp_status        (rsp_chan.status)
   );

   // error beats carry a zero byte and close the field
   `CSVHFS_ASSERT_IMP(a_err_shape, clock, reset, rsp_chan.valid && (rsp_chan.status != ST_BYTE), rsp_chan.last_of_field && (rsp_chan.field_byte == 8'd0))

   // a sent byte shows up on the output in the next cycle
   `CSVHFS_ASSERT_NXT(a_send_shows, clock, reset, cmd.send || cmd.load_single, rsp_chan.valid)

   // no input is taken while a field is being walked out
   `CSVHFS_ASSERT_IMP(a_no_take_busy, clock, reset, cmd.fetch || cmd.send || cmd.load_single, !req_chan.ready)

   // status is one of the three result codes
   `CSVHFS_ASSERT_IMP(a_status_code, clock, reset, rsp_chan.valid, (rsp_chan.status == ST_BYTE) || (rsp_chan.status == ST_EMPTY) || (rsp_chan.status == ST_LONG))

endmodule

`default_nettype wire
